### rtl/gioc_pkg.sv
`timescale 1ns / 1ps

package gioc_pkg;

   localparam int STAVES   = 4;
   localparam int VOICES   = 8;
   localparam int CAPACITY = 256;

   localparam int OP_W     = 2;
   localparam int TICK_W   = 32;
   localparam int VOICE_W  = 3;
   localparam int STAFF_IN_W = 3;
   localparam int STATUS_W = 2;

   localparam int STAFF_W  = $clog2(STAVES);
   localparam int VIDX_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int QDEPTH   = 2;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QLVL_W   = $clog2(QDEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_QUERY = 2'd2,
      OP_SPARE = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK            = 2'd0,
      STATUS_STAFF_IGNORED = 2'd1,
      STATUS_DROPPED       = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CMD_ADD,
      CMD_CLEAR,
      CMD_QUERY,
      CMD_STAFF_SKIP,
      CMD_VOICE_DROP,
      CMD_NOP
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_COMMIT
   } back_state_type;

   typedef struct packed {
      logic [OP_W-1:0]         operation;
      logic signed [TICK_W-1:0] start_tick;
      logic signed [TICK_W-1:0] end_tick;
      logic [VOICE_W-1:0]      voice;
      logic [STAFF_IN_W-1:0]   staff;
   } req_type;

   typedef struct packed {
      logic                overlap;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic                    voice_ok;
      logic [VIDX_W-1:0]       voice_idx;
      logic [VOICE_W-1:0]      voice;
      logic [STAFF_W-1:0]      staff;
      logic signed [TICK_W-1:0] start_tick;
      logic signed [TICK_W-1:0] end_tick;
   } cmd_type;

   typedef struct packed {
      logic signed [TICK_W-1:0] start_tick;
      logic signed [TICK_W-1:0] end_tick;
      logic [VOICE_W-1:0]      voice;
      logic [STAFF_W-1:0]      staff;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic             pop;
      logic [CNT_W-1:0] count;
   } bk_status_type;

endpackage

### rtl/grouped_interval_overlap_check_unit.sv
`timescale 1ns / 1ps
// Interval overlap checker, grouped by voice and staff.
// A transaction is taken on a rising edge where start is high and busy is low;
// req_payload carries the operation (add, clear, query), the interval ticks,
// the voice and the staff. Every transaction produces exactly one response,
// shown on rsp_payload for one cycle while rsp_valid is high, in order.
// The front end classifies each transaction and places it in a two-entry
// queue; busy is high only while that queue is full. The back end executes
// one transaction at a time.
// Clear, query and rejected adds are answered without a scan. An accepted add
// scans the stored intervals through the interval memory's single read port,
// one entry per cycle, and then commits the new interval in a final step; at
// most 256 intervals are stored.
// Reset empties the store, the queue and all per-voice overlap flags; no
// clearing pass is needed. The receiver has no way to stall responses, and the
// block needs none.
module grouped_interval_overlap_check_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gioc_pkg::req_type req_payload,
   output logic              rsp_valid,
   output gioc_pkg::rsp_type rsp_payload
);
   import gioc_pkg::*;

   q_status_type  qs;
   bk_status_type bs;
   cmd_type       push_cmd;
   cmd_type       head;
   logic          push;

   gioc_front u_front (
      .start (start),
      .req   (req_payload),
      .qs    (qs),
      .busy  (busy),
      .push  (push),
      .cmd   (push_cmd)
   );

   gioc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (bs.pop),
      .head     (head),
      .qs       (qs)
   );

   gioc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .qs        (qs),
      .bs        (bs),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_payload)
   );

   ap_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      bs.pop |-> !qs.empty)
      else $error("back end took a transaction from an empty queue");

   ap_quick_response: assert property (@(posedge clock) disable iff (reset)
      (bs.pop && head.kind != CMD_ADD) |=> rsp_valid)
      else $error("non-add transaction did not respond in the next cycle");

   ap_count_bound: assert property (@(posedge clock) disable iff (reset)
      bs.count <= CNT_W'(CAPACITY))
      else $error("stored interval count exceeds capacity");

endmodule

### rtl/gioc_front.sv
`timescale 1ns / 1ps

module gioc_front (
   input  logic                  start,
   input  gioc_pkg::req_type     req,
   input  gioc_pkg::q_status_type qs,
   output logic                  busy,
   output logic                  push,
   output gioc_pkg::cmd_type     cmd
);
   import gioc_pkg::*;

   logic voice_ok;
   logic staff_ok;

   assign voice_ok = (32'(req.voice) < VOICES);
   assign staff_ok = (32'(req.staff) < STAVES);

   // The staff check takes priority over the voice check.
   always_comb begin
      cmd.voice_ok   = voice_ok;
      cmd.voice_idx  = req.voice[VIDX_W-1:0];
      cmd.voice      = req.voice;
      cmd.staff      = req.staff[STAFF_W-1:0];
      cmd.start_tick = req.start_tick;
      cmd.end_tick   = req.end_tick;
      case (op_type'(req.operation))
         OP_ADD: begin
            if (!staff_ok) begin
               cmd.kind = CMD_STAFF_SKIP;
            end else if (!voice_ok) begin
               cmd.kind = CMD_VOICE_DROP;
            end else begin
               cmd.kind = CMD_ADD;
            end
         end
         OP_CLEAR: cmd.kind = CMD_CLEAR;
         OP_QUERY: cmd.kind = CMD_QUERY;
         default:  cmd.kind = CMD_NOP;
      endcase
   end

   assign busy = qs.full;
   assign push = start && !qs.full;

endmodule

### rtl/gioc_queue.sv
`timescale 1ns / 1ps

module gioc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  gioc_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output gioc_pkg::cmd_type      head,
   output gioc_pkg::q_status_type qs
);
   import gioc_pkg::*;

   cmd_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0]   level_ff, level_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head     = slot_ff[rd_ptr_ff];
   assign qs.full  = (level_ff == QLVL_W'(QDEPTH));
   assign qs.empty = (level_ff == '0);

endmodule

### rtl/gioc_back.sv
`timescale 1ns / 1ps

module gioc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  gioc_pkg::cmd_type       head,
   input  gioc_pkg::q_status_type  qs,
   output gioc_pkg::bk_status_type bs,
   output logic                    rsp_valid,
   output gioc_pkg::rsp_type       rsp
);
   import gioc_pkg::*;

   back_state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [VOICES-1:0] flags_ff, flags_in;
   cmd_type          cur_ff, cur_in;
   logic             hit_ff, hit_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   entry_type        rd_data_ff;
   entry_type        mem [CAPACITY];
   entry_type        wr_entry;
   logic             mem_we;
   logic             pop;
   logic             room;
   logic             match;

   assign pop  = (state_ff == BK_IDLE) && !qs.empty;
   assign room = (count_ff != CNT_W'(CAPACITY));

   // Two spans miss each other when one starts at or after the other ends.
   assign match = cmp_valid_ff &&
                  (rd_data_ff.voice == cur_ff.voice) &&
                  (rd_data_ff.staff != cur_ff.staff) &&
                  !(($signed(cur_ff.start_tick) >= $signed(rd_data_ff.end_tick)) ||
                    ($signed(cur_ff.end_tick) <= $signed(rd_data_ff.start_tick)));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop && head.kind == CMD_ADD && room) begin
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (idx_ff == count_ff) begin
               state_in = BK_COMMIT;
            end
         end
         BK_COMMIT: state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      flags_in     = flags_ff;
      cur_in       = cur_ff;
      hit_in       = hit_ff || match;
      cmp_valid_in = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               cur_in = head;
               idx_in = '0;
               hit_in = 1'b0;
               rsp_in.overlap = head.voice_ok && flags_ff[head.voice_idx];
               rsp_in.status  = STATUS_OK;
               case (head.kind)
                  CMD_ADD: begin
                     if (!room) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_DROPPED;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in       = '0;
                     flags_in       = '0;
                     rsp_valid_in   = 1'b1;
                     rsp_in.overlap = 1'b0;
                  end
                  CMD_QUERY: rsp_valid_in = 1'b1;
                  CMD_STAFF_SKIP: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = STATUS_STAFF_IGNORED;
                  end
                  CMD_VOICE_DROP: begin
                     rsp_valid_in   = 1'b1;
                     rsp_in.overlap = 1'b0;
                     rsp_in.status  = STATUS_DROPPED;
                  end
                  default: begin
                     rsp_valid_in   = 1'b1;
                     rsp_in.overlap = 1'b0;
                  end
               endcase
            end
         end
         BK_SCAN: begin
            // One stored entry is read per cycle; the compare uses the registered read data.
            if (idx_ff != count_ff) begin
               cmp_valid_in = 1'b1;
               idx_in       = idx_ff + 1'b1;
            end
         end
         BK_COMMIT: begin
            mem_we   = 1'b1;
            count_in = count_ff + 1'b1;
            flags_in[cur_ff.voice_idx] = flags_ff[cur_ff.voice_idx] | hit_ff;
            rsp_valid_in   = 1'b1;
            rsp_in.overlap = flags_ff[cur_ff.voice_idx] | hit_ff;
            rsp_in.status  = STATUS_OK;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         flags_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         flags_ff     <= flags_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cur_ff <= cur_in;
      hit_ff <= hit_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      wr_entry.start_tick = cur_ff.start_tick;
      wr_entry.end_tick   = cur_ff.end_tick;
      wr_entry.voice      = cur_ff.voice;
      wr_entry.staff      = cur_ff.staff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[ADDR_W-1:0]] <= wr_entry;
      end
      rd_data_ff <= mem[idx_ff[ADDR_W-1:0]];
   end

   assign bs.pop   = pop;
   assign bs.count = count_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### verif/grouped_interval_overlap_check_unit_tb.sv
`timescale 1ns / 1ps

module grouped_interval_overlap_check_unit_tb;
   import gioc_pkg::*;

   localparam int CYCLE_LIMIT   = 3000000;
   localparam int SETTLE_CYCLES = CAPACITY + 8;
   localparam int RANDOM_ITEMS  = 1200;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_valid;
   rsp_type rsp_payload;

   grouped_interval_overlap_check_unit uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the interval store and the per-voice sticky flags.
   logic signed [TICK_W-1:0] span_start [CAPACITY];
   logic signed [TICK_W-1:0] span_end   [CAPACITY];
   logic [VOICE_W-1:0]       span_voice [CAPACITY];
   logic [STAFF_IN_W-1:0]    span_staff [CAPACITY];
   int unsigned              span_count = 0;
   logic                     voice_flag [VOICES];

   rsp_type     verdict_q[$];
   rsp_type     expected_verdict;
   int unsigned error_count   = 0;
   int unsigned items_sent    = 0;
   int unsigned cycle_count   = 0;
   bit          steady_stretch = 1'b0;

   initial begin
      foreach (voice_flag[i]) voice_flag[i] = 1'b0;
   end

   function automatic bit spans_collide(logic signed [TICK_W-1:0] s1,
                                        logic signed [TICK_W-1:0] e1,
                                        logic signed [TICK_W-1:0] s2,
                                        logic signed [TICK_W-1:0] e2);
      return !(s1 >= e2 || e1 <= s2);
   endfunction

   // Updates the shadow store for one transaction and returns its verdict.
   function automatic rsp_type apply_overlap_item(req_type item);
      rsp_type     verdict;
      int unsigned v;
      int unsigned st;
      bit          voice_ok;
      v        = item.voice;
      st       = item.staff;
      voice_ok = (v < VOICES);
      verdict  = '0;
      case (op_type'(item.operation))
         OP_ADD: begin
            if (st >= STAVES) begin
               verdict.status  = STATUS_STAFF_IGNORED;
               verdict.overlap = voice_ok ? voice_flag[v] : 1'b0;
            end else if (!voice_ok) begin
               verdict.status = STATUS_DROPPED;
            end else if (span_count >= CAPACITY) begin
               verdict.status  = STATUS_DROPPED;
               verdict.overlap = voice_flag[v];
            end else begin
               for (int i = 0; i < span_count; i++) begin
                  if (span_voice[i] == item.voice && span_staff[i] != item.staff &&
                      spans_collide(item.start_tick, item.end_tick,
                                    span_start[i], span_end[i]))
                     voice_flag[v] = 1'b1;
               end
               span_start[span_count] = item.start_tick;
               span_end[span_count]   = item.end_tick;
               span_voice[span_count] = item.voice;
               span_staff[span_count] = item.staff;
               span_count++;
               verdict.status  = STATUS_OK;
               verdict.overlap = voice_flag[v];
            end
         end
         OP_CLEAR: begin
            span_count = 0;
            foreach (voice_flag[i]) voice_flag[i] = 1'b0;
         end
         OP_QUERY: begin
            verdict.overlap = voice_ok ? voice_flag[v] : 1'b0;
         end
         default: ;
      endcase
      return verdict;
   endfunction

   function automatic req_type make_req(op_type op, logic signed [TICK_W-1:0] s,
                                        logic signed [TICK_W-1:0] e,
                                        int unsigned v, int unsigned st);
      req_type item;
      item.operation  = op;
      item.start_tick = s;
      item.end_tick   = e;
      item.voice      = VOICE_W'(v);
      item.staff      = STAFF_IN_W'(st);
      return item;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      error_count++;
   endtask

   // Start stays high from one transaction to the next unless a gap lowers it.
   task automatic issue_transaction(input req_type item);
      start       <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      verdict_q.insert(verdict_q.size(), apply_overlap_item(item));
      items_sent++;
   endtask

   task automatic hold_off();
      int unsigned pick;
      int unsigned len;
      pick = $urandom_range(0, 99);
      if (steady_stretch || pick < 55)
         len = 0;
      else if (pick < 92)
         len = $urandom_range(1, 3);
      else
         len = $urandom_range(8, 40);
      if (len > 0) begin
         start <= 1'b0;
         repeat (len) @(posedge clock);
      end
   endtask

   task automatic wait_until_drained();
      start <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [TICK_W-1:0] rand_tick();
      if ($urandom_range(0, 15) == 0)
         return $urandom;
      return $urandom_range(0, 300);
   endfunction

   function automatic req_type rand_add();
      logic signed [TICK_W-1:0] s;
      logic signed [TICK_W-1:0] e;
      int unsigned              st;
      s = rand_tick();
      if ($urandom_range(0, 15) == 0)
         e = $urandom;
      else
         e = s + $signed($urandom_range(0, 40)) - 4;
      st = ($urandom_range(0, 9) == 0) ? $urandom_range(STAVES, 7)
                                       : $urandom_range(0, STAVES - 1);
      return make_req(OP_ADD, s, e, $urandom_range(0, 7), st);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (verdict_q.size() == 0) begin
            report_mismatch("response with no transaction pending");
         end else begin
            expected_verdict = verdict_q.pop_front();
            if (rsp_payload.overlap !== expected_verdict.overlap)
               report_mismatch($sformatf("overlap got %0b want %0b",
                                         rsp_payload.overlap, expected_verdict.overlap));
            if (rsp_payload.status !== expected_verdict.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_payload.status, expected_verdict.status));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, verdict_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Touching, empty and reversed spans, the tick extremes, every operation and
   // the ignored staff codes.
   task automatic test_directed_cases();
      logic signed [TICK_W-1:0] lo;
      logic signed [TICK_W-1:0] hi;
      lo = 32'sh8000_0000;
      hi = 32'sh7fff_ffff;
      issue_transaction(make_req(OP_CLEAR, 0, 0, 0, 0));
      issue_transaction(make_req(OP_QUERY, 0, 0, 0, 0));
      issue_transaction(make_req(OP_ADD, 0, 10, 0, 0));
      hold_off();
      issue_transaction(make_req(OP_ADD, 5, 15, 0, 0));
      issue_transaction(make_req(OP_ADD, 10, 20, 0, 1));
      issue_transaction(make_req(OP_ADD, -5, 0, 0, 1));
      issue_transaction(make_req(OP_ADD, lo, hi, 1, 2));
      issue_transaction(make_req(OP_ADD, hi, lo, 1, 3));
      hold_off();
      issue_transaction(make_req(OP_ADD, lo, lo + 1, 1, 0));
      issue_transaction(make_req(OP_ADD, 0, 10, 2, 0));
      issue_transaction(make_req(OP_ADD, 5, 5, 2, 1));
      issue_transaction(make_req(OP_ADD, 9, 11, 0, 2));
      issue_transaction(make_req(OP_QUERY, 0, 0, 0, 5));
      issue_transaction(make_req(OP_QUERY, hi, hi, 1, 7));
      issue_transaction(make_req(OP_QUERY, 0, 0, 2, 0));
      issue_transaction(make_req(OP_QUERY, 0, 0, 7, 0));
      issue_transaction(make_req(OP_ADD, 0, 100, 3, 4));
      issue_transaction(make_req(OP_ADD, lo, hi, 0, 7));
      issue_transaction(make_req(OP_ADD, hi, hi, 7, 3));
      issue_transaction(make_req(OP_SPARE, $urandom, $urandom, 5, 6));
      issue_transaction(make_req(OP_CLEAR, lo, hi, 7, 7));
      issue_transaction(make_req(OP_QUERY, 0, 0, 0, 0));
      wait_until_drained();
   endtask

   // Fills the store, then checks that further adds are dropped while an
   // ignored staff still takes precedence.
   task automatic test_store_full();
      issue_transaction(make_req(OP_CLEAR, 0, 0, 0, 0));
      for (int i = 0; i < CAPACITY; i++) begin
         issue_transaction(make_req(OP_ADD, i * 4, i * 4 + $urandom_range(2, 6),
                                    i % VOICES, (i / VOICES) % STAVES));
         hold_off();
      end
      issue_transaction(make_req(OP_ADD, 0, 1000, 5, 0));
      issue_transaction(make_req(OP_ADD, 0, 1000, 2, 3));
      issue_transaction(make_req(OP_ADD, 0, 1000, 2, 6));
      issue_transaction(make_req(OP_QUERY, 0, 0, 5, 0));
      issue_transaction(make_req(OP_CLEAR, 0, 0, 0, 0));
      issue_transaction(make_req(OP_ADD, 0, 1000, 5, 0));
   endtask

   // Measures of random adds with queries, spare operations and clears mixed in;
   // now and then a measure is longer than the capacity of the store.
   task automatic test_random_measures();
      int unsigned target;
      int unsigned measure_len;
      int unsigned pick;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         steady_stretch = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 7) == 0)
            wait_until_drained();
         issue_transaction(make_req(OP_CLEAR, rand_tick(), rand_tick(),
                                    $urandom_range(0, 7), $urandom_range(0, 7)));
         measure_len = ($urandom_range(0, 24) == 0) ? CAPACITY + $urandom_range(1, 8)
                                                   : $urandom_range(1, 30);
         repeat (measure_len) begin
            hold_off();
            pick = $urandom_range(0, 99);
            if (pick < 72)
               issue_transaction(rand_add());
            else if (pick < 94)
               issue_transaction(make_req(OP_QUERY, $urandom, $urandom,
                                          $urandom_range(0, 7), $urandom_range(0, 7)));
            else if (pick < 98)
               issue_transaction(make_req(OP_SPARE, $urandom, $urandom,
                                          $urandom_range(0, 7), $urandom_range(0, 7)));
            else
               issue_transaction(make_req(OP_CLEAR, $urandom, $urandom,
                                          $urandom_range(0, 7), $urandom_range(0, 7)));
         end
      end
      steady_stretch = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_store_full();
      test_random_measures();
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
